// ===== rtl/tcma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcma_pkg: shared constants for the two-channel converter moving average
// Field widths, default sizes and the per-channel scale factors.
// ----------------------------------------------------------------------------
package tcma_pkg;

    localparam int CHANNEL_W = 1;
    localparam int SAMPLE_W  = 10;
    localparam int SCALED_W  = 16;

    localparam int DEF_CHANNEL_COUNT = 2;
    localparam int DEF_WINDOW_LENGTH = 5;

    // channel codes
    localparam logic [CHANNEL_W-1:0] TEMP_CHANNEL = 1'b0;

    // scaled = mean * SCALE / 2**FULL_SCALE_SHIFT
    localparam int TEMP_SCALE       = 50000;   // hundredths of a degree
    localparam int VOLT_SCALE       = 500;     // hundredths of a volt
    localparam int FULL_SCALE_SHIFT = 10;
    localparam int SCALE_W          = 16;

endpackage

// ===== rtl/tcma_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcma_in_if / tcma_out_if: valid-ready channels of the moving average
// Sample requests in, averaged result requests out.
// ----------------------------------------------------------------------------
interface tcma_in_if;
    import tcma_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface tcma_out_if;
    import tcma_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] out_channel;
    logic [SAMPLE_W-1:0]  mean;
    logic [SCALED_W-1:0]  scaled_value;

    modport source (output valid, output out_channel, output mean, output scaled_value,
                    input ready);
    modport sink   (input valid, input out_channel, input mean, input scaled_value,
                    output ready);
endinterface

// ===== rtl/two_channel_adc_moving_average.sv =====
`timescale 1ns / 1ps
// Requests pass stage A, stage B, the mean stage and the result register to o_out.
// Throughput: one request per cycle unless o_out stalls, set by the running-sum update.
// Stalls on o_out back up stage by stage; empty stages still take new requests.
// Reset clears all valid bits, fill counts, running sums and oldest pointers.
// Window sample storage is not cleared; entries are only read after being written.
// ----------------------------------------------------------------------------
// two_channel_adc_moving_average: per-channel sliding-window mean
// Keeps the last WINDOW_LENGTH samples of each channel and returns the
// truncated mean plus a scaled value (hundredths of a degree on the
// temperature channel, hundredths of a volt on the others).
// ----------------------------------------------------------------------------
module two_channel_adc_moving_average #(
    parameter int CHANNEL_COUNT = tcma_pkg::DEF_CHANNEL_COUNT,
    parameter int WINDOW_LENGTH = tcma_pkg::DEF_WINDOW_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcma_in_if.sink    i_in,
    tcma_out_if.source o_out
);
    import tcma_pkg::*;

    // running sum holds up to WINDOW_LENGTH full-scale samples
    localparam int SUM_W = $clog2(WINDOW_LENGTH * ((1 << SAMPLE_W) - 1) + 1);

    // stage A: input register
    logic                 r_a_valid;
    logic [CHANNEL_W-1:0] r_a_channel;
    logic [SAMPLE_W-1:0]  r_a_sample;

    // stage B: updated window sum of a request that yields a result
    logic                 r_b_valid;
    logic [CHANNEL_W-1:0] r_b_channel;
    logic [SUM_W-1:0]     r_b_sum;

    logic                 w_lane_fire [CHANNEL_COUNT];
    logic [SUM_W-1:0]     w_lane_sum  [CHANNEL_COUNT];
    logic                 w_sel_fire;
    logic [SUM_W-1:0]     w_sel_sum;
    logic                 w_scl_ready;
    logic                 w_b_ok;
    logic                 w_a_move;

    // stage B may load when empty or when its request goes downstream
    assign w_b_ok   = !r_b_valid || w_scl_ready;
    assign w_a_move = r_a_valid && w_b_ok;
    assign i_in.ready = !r_a_valid || w_b_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_a_channel <= i_in.channel;
            r_a_sample  <= i_in.sample;
        end
    end

    // One lane per channel. A channel number with no lane matches nothing,
    // so its request is dropped without touching any lane's state.
    for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_lane
        tcma_lane #(
            .WINDOW_LENGTH (WINDOW_LENGTH),
            .SUM_W         (SUM_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_upd    (w_a_move && (int'(r_a_channel) == c)),
            .i_sample (r_a_sample),
            .o_fire   (w_lane_fire[c]),
            .o_sum    (w_lane_sum[c])
        );
    end

    always_comb begin
        w_sel_fire = 1'b0;
        w_sel_sum  = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (int'(r_a_channel) == c) begin
                w_sel_fire = w_lane_fire[c];
                w_sel_sum  = w_lane_sum[c];
            end
        end
    end

    // a request that leaves its window short of full yields no result: it leaves stage A only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ok) begin
            r_b_valid <= w_a_move && w_sel_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_move && w_sel_fire) begin
            r_b_channel <= r_a_channel;
            r_b_sum     <= w_sel_sum;
        end
    end

    // mean by reciprocal multiply, then per-channel scale into the result register
    tcma_scale #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SUM_W         (SUM_W)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_b_valid),
        .o_ready   (w_scl_ready),
        .i_channel (r_b_channel),
        .i_sum     (r_b_sum),
        .o_out     (o_out)
    );

    a_b_known_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (int'(r_b_channel) < CHANNEL_COUNT))
        else $error("result pending for a channel without a lane");

    a_accept_loads_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_a_valid)
        else $error("accepted sample request lost at input register");

endmodule

// ===== rtl/tcma_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcma_lane: window state of one channel
// Circular sample buffer with running sum, fill count and oldest pointer.
// ----------------------------------------------------------------------------
module tcma_lane #(
    parameter int WINDOW_LENGTH = tcma_pkg::DEF_WINDOW_LENGTH,
    parameter int SUM_W         = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_upd,
    input  logic [tcma_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_fire,
    output logic [SUM_W-1:0]              o_sum
);
    import tcma_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);
    localparam int PTR_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

    logic [SAMPLE_W-1:0] r_win [WINDOW_LENGTH];
    logic [CNT_W-1:0]    r_fill;
    logic [PTR_W-1:0]    r_oldest;
    logic [SUM_W-1:0]    r_sum;

    logic [SUM_W-1:0]    n_sum;
    logic [PTR_W-1:0]    n_oldest;
    logic [PTR_W-1:0]    w_wr_ptr;
    logic [SAMPLE_W-1:0] w_old;
    logic                w_full;

    always_comb begin
        w_full   = (r_fill == CNT_W'(WINDOW_LENGTH));
        // oldest stays at zero while filling, so the fill count is the slot
        w_wr_ptr = w_full ? r_oldest : r_fill[PTR_W-1:0];
        w_old    = w_full ? r_win[r_oldest] : '0;
        n_sum    = r_sum - SUM_W'(w_old) + SUM_W'(i_sample);
        n_oldest = (r_oldest == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : r_oldest + 1'b1;
        o_fire   = w_full || (r_fill == CNT_W'(WINDOW_LENGTH - 1));
        o_sum    = n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            r_win[w_wr_ptr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_oldest <= '0;
            r_sum    <= '0;
        end else if (i_upd) begin
            r_sum <= n_sum;
            if (w_full) begin
                r_oldest <= n_oldest;
            end else begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= WINDOW_LENGTH)
        else $error("fill count beyond window length");

    a_oldest_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> w_full)
        else $error("oldest pointer moved before window was full");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_sum) <= int'(r_fill) * ((1 << SAMPLE_W) - 1))
        else $error("running sum exceeds held samples");

endmodule

// ===== rtl/tcma_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcma_scale: mean and scaled value stages
// Divide by the window length via reciprocal, then scale per channel.
// ----------------------------------------------------------------------------
module tcma_scale #(
    parameter int WINDOW_LENGTH = tcma_pkg::DEF_WINDOW_LENGTH,
    parameter int SUM_W         = 13
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tcma_pkg::CHANNEL_W-1:0] i_channel,
    input  logic [SUM_W-1:0]               i_sum,
    tcma_out_if.source                     o_out
);
    import tcma_pkg::*;

    // exact for every sum below 2**SUM_W
    localparam int SH     = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int RECIP  = ((1 << SH) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam int PROD_W = SUM_W + SH + 1;
    localparam int SPROD_W = SAMPLE_W + SCALE_W;

    logic                 r_c_valid;
    logic [CHANNEL_W-1:0] r_c_channel;
    logic [SAMPLE_W-1:0]  r_c_mean;
    logic                 r_d_valid;
    logic [CHANNEL_W-1:0] r_d_channel;
    logic [SAMPLE_W-1:0]  r_d_mean;
    logic [SCALED_W-1:0]  r_d_scaled;

    logic [PROD_W-1:0]    w_div_prod;
    logic [SCALE_W-1:0]   w_scale;
    logic [SPROD_W-1:0]   w_scl_prod;
    logic                 w_c_ok;
    logic                 w_d_ok;

    always_comb begin
        w_d_ok     = !r_d_valid || o_out.ready;
        w_c_ok     = !r_c_valid || w_d_ok;
        w_div_prod = PROD_W'(i_sum) * PROD_W'(RECIP);
        w_scale    = (r_c_channel == TEMP_CHANNEL) ? SCALE_W'(TEMP_SCALE)
                                                   : SCALE_W'(VOLT_SCALE);
        w_scl_prod = SPROD_W'(r_c_mean) * SPROD_W'(w_scale);
    end

    assign o_ready = w_c_ok;

    // mean stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_c_ok) begin
            r_c_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ok && i_valid) begin
            r_c_channel <= i_channel;
            r_c_mean    <= w_div_prod[SH +: SAMPLE_W];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_d_ok) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_ok && r_c_valid) begin
            r_d_channel <= r_c_channel;
            r_d_mean    <= r_c_mean;
            r_d_scaled  <= w_scl_prod[FULL_SCALE_SHIFT +: SCALED_W];
        end
    end

    assign o_out.valid        = r_d_valid;
    assign o_out.out_channel  = r_d_channel;
    assign o_out.mean         = r_d_mean;
    assign o_out.scaled_value = r_d_scaled;

endmodule
